>>> design/msvt_pkg.sv
// Shared types and constants for the matrix stack vertex transform unit.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package msvt_pkg;

  localparam int STACK_DEPTH_DEF = 20;
  localparam int FRAC_BITS_DEF   = 16;

  typedef enum logic [2:0] {
    OP_XFORM     = 3'd0,
    OP_PUSH      = 3'd1,
    OP_POP       = 3'd2,
    OP_SCALE     = 3'd3,
    OP_TRANSLATE = 3'd4,
    OP_ROTATE    = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    AX_X    = 2'd0,
    AX_Y    = 2'd1,
    AX_Z    = 2'd2,
    AX_NONE = 2'd3
  } axis_t;

  // issue control for one multiply-accumulate step
  typedef struct packed {
    logic valid;
    logic first;
  } lane_ctl_t;

  // what a lane hands to the merge
  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } lane_res_t;

endpackage
`default_nettype wire

>>> design/msvt_lane.sv
// One multiply-accumulate lane: registered 32x32 product, saturating 64-bit sum,
// round-half-up narrowing to 32 bits. Depends on msvt_pkg.
`default_nettype none
module msvt_lane #(
  parameter int FRAC_BITS = msvt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire msvt_pkg::lane_ctl_t ctl,
  input  wire logic signed [31:0]  a,
  input  wire logic signed [31:0]  b,
  output msvt_pkg::lane_res_t      res
);
  import msvt_pkg::*;

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0] prod;
  lane_ctl_t          ctl_d;
  logic signed [63:0] acc;
  logic signed [64:0] sum;
  logic signed [63:0] sum_sat;
  logic signed [64:0] rnd;
  logic signed [63:0] rnd_sat;
  logic signed [63:0] q;

  always_comb begin
    sum = {acc[63], acc} + {prod[63], prod};
    if (sum[64] != sum[63]) begin
      sum_sat = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sum_sat = sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (rst) begin
      ctl_d <= '0;
    end else begin
      ctl_d <= ctl;
    end
    if (ctl_d.valid) begin
      if (ctl_d.first) begin
        acc <= prod;
      end else begin
        acc <= sum_sat;
      end
    end
  end

  // round half up, floor shift, clamp to 32 bits; only the clamp flags saturation
  always_comb begin
    rnd = {acc[63], acc} + {HALF[63], HALF};
    if (rnd[64] != rnd[63]) begin
      rnd_sat = rnd[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      rnd_sat = rnd[63:0];
    end
    q = rnd_sat >>> FRAC_BITS;
    res.sat = 1'b0;
    if (q > 64'sd2147483647) begin
      res.value = 32'sh7fffffff;
      res.sat   = 1'b1;
    end else if (q < -64'sd2147483648) begin
      res.value = 32'sh80000000;
      res.sat   = 1'b1;
    end else begin
      res.value = q[31:0];
    end
  end

endmodule
`default_nettype wire

>>> design/msvt_sincos.sv
// Angle reduction modulo 3600 by restoring subtraction and sine/cosine lookup
// from a quarter-wave ROM built at elaboration. Depends on msvt_pkg.
`default_nettype none
module msvt_sincos #(
  parameter int FRAC_BITS = msvt_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [15:0] angle,
  output logic signed [31:0]      sin_v,
  output logic signed [31:0]      cos_v,
  output logic                    done
);
  import msvt_pkg::*;

  typedef logic [31:0] rom_t [0:900];

  // series term divisors (2n)(2n+1) for n = 1..7
  localparam longint unsigned TERM_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                 64'd156, 64'd210};

  function automatic rom_t build_rom();
    rom_t               r;
    longint unsigned    x, x2, term;
    longint             acc;
    r = '{default: '0};
    for (int i = 0; i <= 900; i++) begin
      x    = ((longint'(i) * 64'd3454217652358) / 1800 + 512) >> 10;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / TERM_DIV[n];
        if (n % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) r[i] = '0;
      else r[i] = 32'((acc + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_RD_S, S_RD_C, S_FIN
  } sc_state_t;

  sc_state_t   state;
  logic [16:0] red;
  logic [2:0]  step;
  logic [31:0] rom_q;
  logic        neg_q;
  logic [16:0] sub_v;
  logic [11:0] a_s;
  logic [12:0] a_c1;
  logic [11:0] a_c;
  logic [9:0]  idx_s, idx_c;
  logic        neg_s, neg_c;

  // quarter fold: index into the quarter wave and the sign
  function automatic logic [10:0] fold(input logic [11:0] a);
    logic [9:0] idx;
    logic       neg;
    if (a < 12'd900) begin
      idx = a[9:0];
      neg = 1'b0;
    end else if (a < 12'd1800) begin
      idx = 10'(12'd1800 - a);
      neg = 1'b0;
    end else if (a < 12'd2700) begin
      idx = 10'(a - 12'd1800);
      neg = 1'b1;
    end else begin
      idx = 10'(12'd3600 - a);
      neg = 1'b1;
    end
    return {neg, idx};
  endfunction

  always_comb begin
    sub_v = 17'd3600 << step;
    a_s   = red[11:0];
    a_c1  = {1'b0, a_s} + 13'd900;
    a_c   = (a_c1 >= 13'd3600) ? 12'(a_c1 - 13'd3600) : a_c1[11:0];
    {neg_s, idx_s} = fold(a_s);
    {neg_c, idx_c} = fold(a_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      case (state)
        S_IDLE: begin
          if (start) begin
            red   <= 17'({angle[15], angle}) + 17'd36000;
            step  <= 3'd4;
            state <= S_RED;
          end
        end
        S_RED: begin
          if (red >= sub_v) red <= red - sub_v;
          if (step == 3'd0) state <= S_RD_S;
          else step <= step - 3'd1;
        end
        S_RD_S: begin
          rom_q <= ROM[idx_s];
          neg_q <= neg_s;
          state <= S_RD_C;
        end
        S_RD_C: begin
          sin_v <= neg_q ? -$signed(rom_q) : $signed(rom_q);
          rom_q <= ROM[idx_c];
          neg_q <= neg_c;
          state <= S_FIN;
        end
        S_FIN: begin
          cos_v <= neg_q ? -$signed(rom_q) : $signed(rom_q);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/matrix_stack_vertex_transform_unit.sv
// Top level of the matrix stack vertex transform unit: command sequencer, current
// matrix, matrix stack memory, four MAC lanes and the merge. Depends on msvt_pkg,
// msvt_lane and msvt_sincos.
//
//  channel  | dir | tdata (low bit up)                        | tuser         | tlast
//  ---------+-----+-------------------------------------------+---------------+------------
//  s_axis   | in  | in_x, in_y, in_z, in_w, angle_tenths      | opcode, axis  | vertex_last
//  m_axis   | out | out_x, out_y, out_z, out_w                | status        | result_last
//
// One command at a time. Transform: one row pass of the lanes, then output. Scale/translate:
// 4 row passes. Rotate adds angle reduction and ROM lookup. Push and pop move one stack
// word per cycle through the single memory port. Reset (rst, synchronous) loads the
// identity and empties the stack; stack contents are left as they are. A finished word
// waits in the output register; the next command is taken meanwhile, and only a second
// finish stalls on it.
`default_nettype none
module matrix_stack_vertex_transform_unit #(
  parameter int STACK_DEPTH = msvt_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = msvt_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [143:0] s_tdata,   // in_x, in_y, in_z, in_w, angle_tenths
  input  wire logic [4:0]   s_tuser,   // opcode[2:0], axis[4:3]
  input  wire logic         s_tlast,   // vertex_last
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,   // out_x, out_y, out_z, out_w
  output logic [1:0]        m_tuser,   // status
  output logic              m_tlast    // result_last
);
  import msvt_pkg::*;

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH * 16);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  // diagonal positions of a row-major 4x4 matrix
  localparam logic [15:0] DIAG = 16'h8421;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ANG, ST_MAC, ST_WAIT, ST_CAP, ST_PUSH, ST_POP, ST_FIN
  } state_t;

  state_t             state;
  opcode_t            op;
  axis_t              rot_ax;
  logic signed [31:0] vin [0:3];
  logic               lastr;
  logic signed [31:0] d   [0:15];
  logic signed [31:0] d_init [0:15];
  logic signed [31:0] mat [0:15];
  logic signed [31:0] tm  [0:15];
  logic [1:0]         row, k;
  logic [4:0]         cnt;
  logic               sat;
  status_t            stat;
  logic               commit;
  logic [LW-1:0]      lvl;
  logic               fin_fire;

  logic signed [31:0] stk [0:STACK_DEPTH*16-1];
  logic signed [31:0] stk_q;
  logic [AW-1:0]      stk_addr;

  logic               accept;
  opcode_t            in_op;
  axis_t              in_ax;
  logic signed [31:0] in_v [0:3];

  lane_ctl_t          ctl;
  logic signed [31:0] a_sel;
  logic signed [31:0] b_sel [0:3];
  lane_res_t          lres  [0:3];

  logic               sc_start, sc_done;
  logic signed [31:0] sin_v, cos_v;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_op    = opcode_t'(s_tuser[2:0]);
  assign in_ax    = axis_t'(s_tuser[4:3]);
  assign sc_start = accept && (in_op == OP_ROTATE) && (in_ax != AX_NONE);
  assign stk_addr = AW'({lvl, cnt[3:0]});
  assign fin_fire = (state == ST_FIN) && (!m_tvalid || m_tready);

  always_comb begin
    for (int i = 0; i < 4; i++) in_v[i] = s_tdata[32*i +: 32];
  end

  // build matrix for scale and translate; identity for everything else
  always_comb begin
    for (int i = 0; i < 16; i++) d_init[i] = DIAG[i] ? ONE : '0;
    case (in_op)
      OP_SCALE: begin
        d_init[0]  = in_v[0];
        d_init[5]  = in_v[1];
        d_init[10] = in_v[2];
      end
      OP_TRANSLATE: begin
        d_init[12] = in_v[0];
        d_init[13] = in_v[1];
        d_init[14] = in_v[2];
      end
      default: ;
    endcase
  end

  // lanes: lane j owns column j of the current matrix
  always_comb begin
    ctl.valid = (state == ST_MAC);
    ctl.first = (k == 2'd0);
    a_sel     = (op == OP_XFORM) ? vin[k] : d[{row, k}];
    for (int j = 0; j < 4; j++) b_sel[j] = mat[{k, 2'(j)}];
  end

  for (genvar j = 0; j < 4; j++) begin : g_lane
    msvt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk (clk),
      .rst (rst),
      .ctl (ctl),
      .a   (a_sel),
      .b   (b_sel[j]),
      .res (lres[j])
    );
  end

  msvt_sincos #(.FRAC_BITS(FRAC_BITS)) u_sincos (
    .clk   (clk),
    .rst   (rst),
    .start (sc_start),
    .angle (s_tdata[143:128]),
    .sin_v (sin_v),
    .cos_v (cos_v),
    .done  (sc_done)
  );

  // stack memory: one port, registered read
  always_ff @(posedge clk) begin
    if (state == ST_PUSH) stk[stk_addr] <= mat[cnt[3:0]];
    stk_q <= stk[stk_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      lvl      <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 16; i++) mat[i] <= DIAG[i] ? ONE : '0;
    end else begin
      // raise valid on a finish, drop it once the word is taken
      if (fin_fire) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op     <= in_op;
            rot_ax <= in_ax;
            lastr  <= s_tlast;
            sat    <= 1'b0;
            stat   <= ST_OK;
            commit <= 1'b0;
            row    <= '0;
            k      <= '0;
            cnt    <= '0;
            for (int i = 0; i < 4; i++) vin[i] <= in_v[i];
            for (int i = 0; i < 16; i++) d[i] <= d_init[i];
            case (in_op)
              OP_XFORM: state <= ST_MAC;
              OP_PUSH: begin
                if (32'(lvl) >= STACK_DEPTH) begin
                  stat  <= ST_FULL;
                  state <= ST_FIN;
                end else begin
                  state <= ST_PUSH;
                end
              end
              OP_POP: begin
                if (lvl == '0) begin
                  stat  <= ST_EMPTY;
                  state <= ST_FIN;
                end else begin
                  lvl   <= lvl - 1'b1;
                  state <= ST_POP;
                end
              end
              OP_SCALE: begin
                commit <= 1'b1;
                state  <= ST_MAC;
              end
              OP_TRANSLATE: begin
                commit <= 1'b1;
                state  <= ST_MAC;
              end
              OP_ROTATE: begin
                if (in_ax == AX_NONE) begin
                  state <= ST_FIN;
                end else begin
                  commit <= 1'b1;
                  state  <= ST_ANG;
                end
              end
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_ANG: begin
          // build the rotation once sine and cosine arrive
          if (sc_done) begin
            case (rot_ax)
              AX_X: begin
                d[5] <= cos_v;  d[6] <= sin_v;  d[9] <= -sin_v; d[10] <= cos_v;
              end
              AX_Y: begin
                d[0] <= cos_v;  d[2] <= -sin_v; d[8] <= sin_v;  d[10] <= cos_v;
              end
              default: begin
                d[0] <= cos_v;  d[1] <= sin_v;  d[4] <= -sin_v; d[5] <= cos_v;
              end
            endcase
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          k <= k + 2'd1;
          if (k == 2'd3) state <= ST_WAIT;
        end
        ST_WAIT: state <= ST_CAP;
        ST_CAP: begin
          // merge: collect the row, fold the lane saturation flags
          for (int j = 0; j < 4; j++) begin
            tm[{row, 2'(j)}] <= lres[j].value;
          end
          sat <= sat | lres[0].sat | lres[1].sat | lres[2].sat | lres[3].sat;
          if (op == OP_XFORM || row == 2'd3) begin
            state <= ST_FIN;
          end else begin
            row   <= row + 2'd1;
            state <= ST_MAC;
          end
        end
        ST_PUSH: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            lvl   <= lvl + 1'b1;
            state <= ST_FIN;
          end
        end
        ST_POP: begin
          if (cnt != 5'd0) mat[4'(cnt - 5'd1)] <= stk_q;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd16) state <= ST_FIN;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (fin_fire) begin
            m_tlast  <= lastr;
            m_tuser  <= sat ? ST_SAT : stat;
            if (op == OP_XFORM) begin
              m_tdata <= {tm[3], tm[2], tm[1], tm[0]};
            end else begin
              m_tdata <= '0;
            end
            if (commit) begin
              for (int i = 0; i < 16; i++) mat[i] <= tm[i];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
